// ===== design/mpma_pkg.sv =====
// Shared constants and types for the max-plus matrix product with argmax.
package mpma_pkg;

  localparam int unsigned K_MAX_DEF = 64;
  localparam int unsigned J_MAX_DEF = 64;

  localparam int unsigned CNT_W   = 7;   // width of the count registers
  localparam int unsigned IDX_W   = 6;   // width of k_index, j_index, best_k, column
  localparam int unsigned VAL_W   = 32;  // Q16.16 input value
  localparam int unsigned SUM_W   = 33;  // Q17.16 sum

  // Register indexes of the configuration port
  localparam logic REG_K_COUNT = 1'b0;
  localparam logic REG_J_COUNT = 1'b1;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_ROW  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

endpackage

// ===== design/max_plus_matmul_argmax.sv =====
// Top level of the max-plus matrix product with argmax.
// Usage:
//   Requests enter on start while busy is low. A load request (func = 0)
//   writes value into the right-hand store at row k_index, column j_index;
//   it leaves busy low. A row request (func = 1) carries the left-hand
//   element a[k_index] and sweeps the columns 0..j_count-1, one column per
//   cycle: the store entry and the running max/argmax of the column are
//   read from two synchronous memories, the sum is compared in the next
//   cycle and written back. busy stays high through the sweep and the drain
//   state that follows it, so no new request is taken until the sweep is
//   through. When k_index equals k_count - 1 the sweep also emits one
//   result per column on result_valid, registered after the compare stage,
//   one per cycle, last set on the final column. The receiver cannot stall;
//   results are shown for exactly one cycle.
//   Configuration: wr_en with wr_index 0 (k_count) or 1 (j_count), only
//   while idle. Counts are clamped to their legal range.
//   Reset: rst clears the controller and sets both counts to 64; the
//   memories keep their contents and need no clearing pass.
module max_plus_matmul_argmax
  import mpma_pkg::*;
#(
  parameter int unsigned K_MAX = K_MAX_DEF,
  parameter int unsigned J_MAX = J_MAX_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic                    func,
  input  logic [IDX_W-1:0]        k_index,
  input  logic [IDX_W-1:0]        j_index,
  input  logic signed [VAL_W-1:0] value,
  // configuration port
  input  logic                    wr_en,
  input  logic                    wr_index,
  input  logic [CNT_W-1:0]        wr_data,
  // result channel
  output logic                    result_valid,
  output logic signed [SUM_W-1:0] peak_sum,
  output logic [IDX_W-1:0]        best_k,
  output logic [IDX_W-1:0]        column,
  output logic                    last
);

  // Only rows reachable by a 6-bit k_index are stored
  localparam int unsigned K_ROWS = (K_MAX < (1 << IDX_W)) ? K_MAX : (1 << IDX_W);
  localparam int unsigned CW     = (J_MAX > 1) ? $clog2(J_MAX) : 1;
  localparam int unsigned S_DEPTH = K_ROWS * J_MAX;
  localparam int unsigned AW     = (S_DEPTH > 1) ? $clog2(S_DEPTH) : 1;
  localparam int unsigned RW     = SUM_W + IDX_W;

  // Configuration registers
  logic [CNT_W-1:0] k_count;
  logic [CNT_W-1:0] j_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= CNT_W'(64);
      j_count <= CNT_W'(64);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_K_COUNT: k_count <= wr_data;
        REG_J_COUNT: j_count <= wr_data;
        default:     ;
      endcase
    end
  end

  // Clamp the counts into range
  logic [CNT_W-1:0] kc_eff;
  logic [CNT_W-1:0] jc_eff;

  always_comb begin
    if (k_count == '0) begin
      kc_eff = CNT_W'(1);
    end else if (k_count > CNT_W'(K_ROWS)) begin
      kc_eff = CNT_W'(K_ROWS);
    end else begin
      kc_eff = k_count;
    end
    if (j_count == '0) begin
      jc_eff = CNT_W'(1);
    end else if (j_count > CNT_W'(J_MAX)) begin
      jc_eff = CNT_W'(J_MAX);
    end else begin
      jc_eff = j_count;
    end
  end

  // Controller
  state_t state;
  state_t state_next;
  logic   accept;
  logic   sweep;
  logic   col_end;

  logic [CW-1:0]          col;
  logic [IDX_W-1:0]       k_lat;
  logic signed [VAL_W-1:0] a_lat;
  logic                   emit;

  assign accept  = start && !busy;
  assign col_end = (CNT_W'(col) == jc_eff - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && func == FUNC_ROW) state_next = ST_SWEEP;
      ST_SWEEP: if (col_end) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    sweep = 1'b0;
    unique case (state)
      ST_IDLE:  busy  = 1'b0;
      ST_SWEEP: sweep = 1'b1;
      ST_DRAIN: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the row request; advance the column during the sweep
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_ROW) begin
      k_lat <= k_index;
      a_lat <= value;
      emit  <= (CNT_W'(k_index) == kc_eff - CNT_W'(1));
      col   <= '0;
    end else if (sweep && !col_end) begin
      col <= col + CW'(1);
    end
  end

  // Right-hand store
  logic signed [VAL_W-1:0] store_mem [S_DEPTH];
  logic signed [VAL_W-1:0] store_q;
  logic [AW-1:0]           load_addr;
  logic [AW-1:0]           rd_addr;
  logic                    load_ok;
  logic                    k_ok;

  assign load_ok   = (32'(k_index) < K_ROWS) && (32'(j_index) < J_MAX);
  assign load_addr = AW'(32'(k_index) * J_MAX + 32'(j_index));
  assign k_ok      = (32'(k_lat) < K_ROWS);
  assign rd_addr   = AW'(32'(k_lat) * J_MAX + 32'(col));

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD && load_ok) begin
      store_mem[load_addr] <= value;
    end
    if (sweep) begin
      store_q <= store_mem[rd_addr];
    end
  end

  // Running max/argmax memory, {max, arg} per column
  logic [RW-1:0] run_mem [J_MAX];
  logic [RW-1:0] run_q;

  // Compare stage
  logic          p_valid;
  logic [CW-1:0] p_col;
  logic          p_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep) begin
      run_q  <= run_mem[col];
      p_col  <= col;
      p_last <= col_end;
    end
  end

  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] old_max;
  logic                    take;
  logic signed [SUM_W-1:0] new_max;
  logic [IDX_W-1:0]        new_arg;

  always_comb begin
    b_ext   = k_ok ? SUM_W'(store_q) : '0;
    sum     = SUM_W'(a_lat) + b_ext;
    old_max = run_q[RW-1:IDX_W];
    take    = (k_lat == '0) || (sum > old_max);
    new_max = take ? sum : old_max;
    new_arg = take ? k_lat : run_q[IDX_W-1:0];
  end

  // Write back the updated column
  always_ff @(posedge clk) begin
    if (p_valid) begin
      run_mem[p_col] <= {new_max, new_arg};
    end
  end

  // Result registers; drop results of rows that do not end here
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= p_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      peak_sum <= new_max;
      best_k   <= new_arg;
      column   <= IDX_W'(p_col);
      last     <= p_last;
    end
  end

endmodule

// ===== sim/max_plus_matmul_argmax_test.sv =====
// Testbench for the max-plus matrix product with argmax: predicts every column result and checks it.
module max_plus_matmul_argmax_test;
  import mpma_pkg::*;

  // Idle wait after a drain that lets a row sweep emitting no results run out.
  localparam int unsigned SWEEP_CYCLES = J_MAX_DEF + 6;
  // Cycles with no request, result or register write before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    logic                    fn;
    logic [IDX_W-1:0]        k;
    logic [IDX_W-1:0]        j;
    logic signed [VAL_W-1:0] v;
  } request_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        arg;
    logic [IDX_W-1:0]        col;
    logic                    fin;
  } col_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    func = FUNC_LOAD;
  logic [IDX_W-1:0]        k_index = '0;
  logic [IDX_W-1:0]        j_index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    wr_en = 1'b0;
  logic                    wr_index = REG_K_COUNT;
  logic [CNT_W-1:0]        wr_data = '0;
  logic                    result_valid;
  logic signed [SUM_W-1:0] peak_sum;
  logic [IDX_W-1:0]        best_k;
  logic [IDX_W-1:0]        column;
  logic                    last;

  max_plus_matmul_argmax u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .k_index      (k_index),
    .j_index      (j_index),
    .value        (value),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .result_valid (result_valid),
    .peak_sum     (peak_sum),
    .best_k       (best_k),
    .column       (column),
    .last         (last)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and column results the block still owes.
  request_t    request_queue [$];
  col_result_t row_results_due [$];

  // Shadow of the block: effective counts, right-hand store, running max/argmax.
  int unsigned             k_len = 64;
  int unsigned             j_len = 64;
  logic signed [VAL_W-1:0] b_store [64][64];
  logic signed [SUM_W-1:0] run_max [64];
  logic [IDX_W-1:0]        run_arg [64];

  // What the stimulus side has written so far, so it never reads an unwritten
  // store entry or a running value that no row start has set.
  bit gen_b_set [64][64];
  bit gen_run_set [64];

  int unsigned send_idle_pct = 24;
  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_elems = 0;
  int unsigned n_results = 0;
  int unsigned n_settings = 0;
  int unsigned n_pushed = 0;
  int unsigned idle_cycles = 0;
  request_t    nxt;
  col_result_t want;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got, exp_val);
    n_errors++;
  endtask

  function automatic int unsigned clamp_count(logic [CNT_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > 64) return 64;
    return 32'(raw);
  endfunction

  // Apply one accepted request to the shadow state and queue the row results it causes.
  task automatic max_plus_step(logic fn, logic [IDX_W-1:0] k, logic [IDX_W-1:0] j,
                               logic signed [VAL_W-1:0] a);
    logic signed [SUM_W-1:0] s;
    col_result_t res;
    if (fn == FUNC_LOAD) begin
      b_store[k][j] = a;
      n_loads++;
    end else begin
      n_elems++;
      for (int c = 0; c < j_len; c++) begin
        // sign-extend both to 33 bits: the sum is exact
        s = {a[VAL_W-1], a} + {b_store[k][c][VAL_W-1], b_store[k][c]};
        // the row start resets the column; later elements replace only on strictly greater
        if (k == 0 || s > run_max[c]) begin
          run_max[c] = s;
          run_arg[c] = k;
        end
      end
      if (32'(k) == k_len - 1) begin
        for (int c = 0; c < j_len; c++) begin
          res.sum = run_max[c];
          res.arg = run_arg[c];
          res.col = IDX_W'(c);
          res.fin = (c == j_len - 1);
          row_results_due.push_back(res);
        end
      end
    end
  endtask

  // Driver: hold a request until start && !busy, then advance to the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        max_plus_step(func, k_index, j_index, value);
      end
      if (!start || !busy) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_queue.pop_front();
          start   <= 1'b1;
          func    <= nxt.fn;
          k_index <= nxt.k;
          j_index <= nxt.j;
          value   <= nxt.v;
        end else begin
          // drop start and scramble the idle fields so nothing leaks through
          start   <= 1'b0;
          func    <= 1'($urandom_range(1));
          k_index <= IDX_W'($urandom);
          j_index <= IDX_W'($urandom);
          value   <= $urandom;
        end
      end
    end
  end

  // Monitor: every strobed result is compared with the oldest expected column.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (row_results_due.size() == 0) begin
        report_mismatch("result with none expected, column", 64'(column), 64'(0));
      end else begin
        want = row_results_due.pop_front();
        n_results++;
        if (peak_sum !== want.sum) report_mismatch("peak_sum", 64'(peak_sum), 64'(want.sum));
        if (best_k !== want.arg) report_mismatch("best_k", 64'(best_k), 64'(want.arg));
        if (column !== want.col) report_mismatch("column", 64'(column), 64'(want.col));
        if (last !== want.fin) report_mismatch("last", 64'(last), 64'(want.fin));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic push_req(logic fn, logic [IDX_W-1:0] k, logic [IDX_W-1:0] j,
                          logic signed [VAL_W-1:0] v);
    request_t r;
    r.fn = fn;
    r.k  = k;
    r.j  = j;
    r.v  = v;
    request_queue.push_back(r);
    n_pushed++;
    if (fn == FUNC_LOAD) begin
      gen_b_set[k][j] = 1'b1;
    end else if (k == 0) begin
      for (int c = 0; c < j_len; c++) gen_run_set[c] = 1'b1;
    end
  endtask

  // Extremes, small values for ties, and plain random words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2, 3: return $urandom_range(4) - 2;
      default: return $urandom;
    endcase
  endfunction

  // A row element at k is legal once its store entries and running values exist.
  function automatic bit elem_ok(int unsigned k);
    for (int c = 0; c < j_len; c++) begin
      if (!gen_b_set[k][c]) return 1'b0;
      if (k != 0 && !gen_run_set[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Wait until every request is taken and every owed result has come.
  task automatic drain();
    while (request_queue.size() != 0 || start || row_results_due.size() != 0) @(posedge clk);
  endtask

  // Drain, then let a sweep that emits nothing run out before touching registers.
  task automatic settle();
    drain();
    repeat (SWEEP_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(logic idx, logic [CNT_W-1:0] raw);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= raw;
    @(posedge clk);
    wr_en    <= 1'b0;
    if (idx == REG_K_COUNT) k_len = clamp_count(raw);
    else j_len = clamp_count(raw);
    n_settings++;
  endtask

  // Fill the store for the rows a well-formed row reads, plus two spare rows
  // for elements past the row end; rewrite some old entries for fresh data.
  task automatic load_block();
    int unsigned kfill;
    kfill = (k_len + 2 > 64) ? 64 : k_len + 2;
    for (int k = 0; k < kfill; k++) begin
      for (int c = 0; c < j_len; c++) begin
        if (!gen_b_set[k][c] || $urandom_range(3) == 0) begin
          push_req(FUNC_LOAD, IDX_W'(k), IDX_W'(c), pick_value());
        end
      end
    end
  endtask

  task automatic stream_row();
    for (int k = 0; k < k_len; k++) push_req(FUNC_ROW, IDX_W'(k), IDX_W'($urandom), pick_value());
  endtask

  int unsigned mode;
  int unsigned ph;
  int unsigned phase_start;
  int unsigned pick;
  int unsigned kk;
  bit          paused;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: 2 by 3 product with the value extremes in the store.
    set_count(REG_K_COUNT, 2);
    set_count(REG_J_COUNT, 3);
    push_req(FUNC_LOAD, 0, 0, 32'sh7FFFFFFF);
    push_req(FUNC_LOAD, 0, 1, 32'sh80000000);
    push_req(FUNC_LOAD, 0, 2, 0);
    push_req(FUNC_LOAD, 1, 0, 32'sh7FFFFFFF);
    push_req(FUNC_LOAD, 1, 1, 32'sh80000000);
    push_req(FUNC_LOAD, 1, 2, 0);
    push_req(FUNC_LOAD, 63, 63, 32'sh80000000);
    // equal elements: every column ties, the first index must win
    push_req(FUNC_ROW, 0, 63, 32'sh7FFFFFFF);
    push_req(FUNC_ROW, 1, 0, 32'sh7FFFFFFF);
    // most negative sum at k = 0, then a strictly greater one at k = 1
    push_req(FUNC_ROW, 0, 0, 32'sh80000000);
    push_req(FUNC_ROW, 1, 0, 32'sh80000001);
    // out of order: row end first against the old running state, then a restart
    push_req(FUNC_ROW, 1, 5, 3);
    push_req(FUNC_ROW, 0, 0, 7);
    push_req(FUNC_ROW, 1, 0, 7);
    push_req(FUNC_ROW, 1, 0, 8);
    settle();

    // Extremes: k_count low clamp, j_count high clamp; one element is a whole row.
    set_count(REG_K_COUNT, 0);
    set_count(REG_J_COUNT, 127);
    // only store row 0 is read here
    for (int c = 0; c < j_len; c++) begin
      if (!gen_b_set[0][c] || $urandom_range(3) == 0) begin
        push_req(FUNC_LOAD, 0, IDX_W'(c), pick_value());
      end
    end
    push_req(FUNC_ROW, 0, 0, 32'sh7FFFFFFF);
    push_req(FUNC_ROW, 0, 0, 32'sh80000000);
    push_req(FUNC_ROW, 0, 0, pick_value());
    settle();

    // Extremes: k_count at 64 (high clamp), single column, a full-length row.
    set_count(REG_J_COUNT, 1);
    set_count(REG_K_COUNT, 64);
    set_count(REG_K_COUNT, 127);
    load_block();
    stream_row();
    for (int i = 0; i < 8; i++) push_req(FUNC_ROW, IDX_W'($urandom_range(63)), 0, pick_value());
    settle();

    // Random: sender idles 24 %, then 76 %, then never.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 76 : 0;
      for (ph = 0; ph < 3; ph++) begin
        settle();
        set_count(REG_K_COUNT, CNT_W'($urandom_range(8)));
        set_count(REG_J_COUNT, CNT_W'($urandom_range(8)));
        load_block();
        phase_start = n_pushed;
        paused = 1'b0;
        while (n_pushed - phase_start < 12) begin
          // hold the sender once per phase until the block has delivered everything
          if (!paused && n_pushed - phase_start >= 6) begin
            drain();
            paused = 1'b1;
          end
          pick = $urandom_range(9);
          if (pick < 7) begin
            stream_row();
          end else if (pick == 7) begin
            push_req(FUNC_LOAD, IDX_W'($urandom_range(k_len - 1)),
                     IDX_W'($urandom_range(j_len - 1)), pick_value());
          end else begin
            // stray element: any index that is safe to read, else a row restart
            kk = $urandom_range(63);
            if (!elem_ok(kk)) kk = 0;
            push_req(FUNC_ROW, IDX_W'(kk), IDX_W'($urandom), pick_value());
          end
        end
      end
    end

    settle();
    $display("covered %0d loads, %0d row elements and %0d column results", n_loads, n_elems,
             n_results);
    $display("over %0d count writes and three sender idle rates; %0d mismatches", n_settings,
             n_errors);
    if (n_errors == 0 && row_results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mpma_pkg.sv
design/max_plus_matmul_argmax.sv
sim/max_plus_matmul_argmax_test.sv
